// File: sv/hsdt_pkg.sv
package hsdt_pkg;

  localparam int PHASE_BITS = 3;
  localparam int TICK_BITS  = 32;
  localparam int FREQ_BITS  = 32;
  localparam int SPEED_BITS = 40;
  localparam int FRAC_BITS  = 8;

  localparam logic [FREQ_BITS-1:0] FREQ_RESET = 32'd1000000;

  localparam logic [1:0] OUT_EDGE  = 2'd0;
  localparam logic [1:0] OUT_EMPTY = 2'd1;
  localparam logic [1:0] OUT_SPEED = 2'd2;

  localparam logic FUNC_EDGE  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                  func;
    logic [PHASE_BITS-1:0] hall_phase;
    logic [TICK_BITS-1:0]  capture_ticks;
  } in_item_t;

  typedef struct packed {
    logic                  direction;
    logic [SPEED_BITS-1:0] speed_q8;
    logic                  speed_valid;
  } out_item_t;

  typedef struct packed {
    logic       load_in;
    logic       edge_upd;
    logic       div_start_avg;
    logic       div_start_speed;
    logic       div_step;
    logic       div_fill_ones;
    logic       acc_clear;
    logic       out_load;
    logic [1:0] out_kind;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic div_last;
    logic quo_zero;
    logic out_busy;
  } stat_t;

  // Phase that follows the given one when the rotor turns counter-clockwise.
  function automatic logic [PHASE_BITS-1:0] ccw_successor(input logic [PHASE_BITS-1:0] phase);
    logic [PHASE_BITS-1:0] succ;
    begin
      case (phase)
        3'd1:    succ = 3'd5;
        3'd2:    succ = 3'd3;
        3'd3:    succ = 3'd1;
        3'd4:    succ = 3'd6;
        3'd5:    succ = 3'd4;
        3'd6:    succ = 3'd2;
        default: succ = 3'd0;
      endcase
      return succ;
    end
  endfunction

endpackage

// File: sv/hsdt_ctrl.sv
module hsdt_ctrl
  import hsdt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_func,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EDGE = 3'd1;
  localparam logic [2:0] S_QRY  = 3'd2;
  localparam logic [2:0] S_DIV1 = 3'd3;
  localparam logic [2:0] S_AVG  = 3'd4;
  localparam logic [2:0] S_DIV2 = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.out_kind = OUT_EDGE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = (in_func == FUNC_QUERY) ? S_QRY : S_EDGE;
        end
      end
      S_EDGE: begin
        if (!st.out_busy) begin
          cmd.edge_upd = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_kind = OUT_EDGE;
          state_next   = S_IDLE;
        end
      end
      S_QRY: begin
        if (st.empty) begin
          if (!st.out_busy) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = OUT_EMPTY;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.div_start_avg = 1'b1;
          state_next        = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_AVG;
        end
      end
      S_AVG: begin
        if (st.quo_zero) begin
          cmd.div_fill_ones = 1'b1;
          state_next        = S_FIN;
        end else begin
          cmd.div_start_speed = 1'b1;
          state_next          = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.out_kind  = OUT_SPEED;
          cmd.acc_clear = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/hsdt_dp.sv
module hsdt_dp
  import hsdt_pkg::*;
#(
  parameter int SUM_BITS   = 40,
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [FREQ_BITS-1:0] cfg_wdata,
  input  in_item_t             in_data,
  output out_item_t            out_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  cmd_t                 cmd,
  output stat_t                st
);

  localparam int DW = (SUM_BITS > SPEED_BITS) ? SUM_BITS : SPEED_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [FREQ_BITS-1:0]  timer_freq;
  in_item_t              item;
  logic [PHASE_BITS-1:0] prev_phase;
  logic [SUM_BITS-1:0]   sum;
  logic [COUNT_BITS-1:0] count;
  logic                  dir;

  logic [DW-1:0] div_rem;
  logic [DW-1:0] div_quo;
  logic [DW-1:0] div_den;
  logic [CW-1:0] div_cnt;

  logic [SUM_BITS:0]     sum_wide;
  logic [SUM_BITS-1:0]   sum_next;
  logic                  dir_next;
  logic [DW:0]           partial;
  logic [DW:0]           diff;

  assign sum_wide = {1'b0, sum} + (SUM_BITS + 1)'(item.capture_ticks);
  assign sum_next = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
  assign dir_next = (ccw_successor(item.hall_phase) == prev_phase);

  assign partial = {div_rem, div_quo[DW-1]};
  assign diff    = partial - {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_freq <= FREQ_RESET;
    end else if (cfg_we) begin
      timer_freq <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phase <= '0;
      sum        <= '0;
      count      <= '0;
      dir        <= 1'b0;
    end else if (cmd.edge_upd) begin
      prev_phase <= item.hall_phase;
      sum        <= sum_next;
      if (count != {COUNT_BITS{1'b1}}) begin
        count <= count + COUNT_BITS'(1);
      end
      dir <= dir_next;
    end else if (cmd.acc_clear) begin
      sum   <= '0;
      count <= '0;
    end
  end

  // Shared restoring divider, one quotient bit per clock.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start_avg || cmd.div_start_speed) begin
      div_cnt <= CW'(DW);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start_avg) begin
      div_rem <= '0;
      div_quo <= DW'(sum);
      div_den <= DW'(count);
    end else if (cmd.div_start_speed) begin
      div_rem <= '0;
      div_quo <= DW'({timer_freq, {FRAC_BITS{1'b0}}});
      div_den <= div_quo;
    end else if (cmd.div_fill_ones) begin
      div_quo <= {DW{1'b1}};
    end else if (cmd.div_step) begin
      if (!diff[DW]) begin
        div_rem <= diff[DW-1:0];
        div_quo <= {div_quo[DW-2:0], 1'b1};
      end else begin
        div_rem <= partial[DW-1:0];
        div_quo <= {div_quo[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_kind)
        OUT_EDGE: begin
          out_data.direction   <= dir_next;
          out_data.speed_q8    <= '0;
          out_data.speed_valid <= 1'b0;
        end
        OUT_SPEED: begin
          out_data.direction   <= dir;
          out_data.speed_q8    <= div_quo[SPEED_BITS-1:0];
          out_data.speed_valid <= 1'b1;
        end
        default: begin
          out_data.direction   <= dir;
          out_data.speed_q8    <= '0;
          out_data.speed_valid <= 1'b0;
        end
      endcase
    end
  end

  assign st.empty    = (sum == '0) || (count == '0);
  assign st.div_last = (div_cnt == CW'(1));
  assign st.quo_zero = (div_quo == '0);
  assign st.out_busy = out_valid && !out_ready;

`ifndef ASSERT_OFF
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> div_cnt != '0)
    else $error("Divider stepped past its last quotient bit.");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_clear |=> (sum == '0) && (count == '0))
    else $error("Accumulators not cleared after a speed query.");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    cmd.edge_upd && (count == {COUNT_BITS{1'b1}}) |=> count == {COUNT_BITS{1'b1}})
    else $error("Edge count wrapped instead of saturating.");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !st.out_busy)
    else $error("Result register overwritten before its transfer.");
`endif

endmodule

// File: sv/hall_speed_direction_tracker.sv
// Hall sensor speed and direction tracker. Each input transfer is a hall edge
// (func 0) or a speed query (func 1) and yields exactly one output transfer. An
// edge updates the accumulators and loads its result once the result register
// is free; a query runs the shared radix-2 divider that first forms the average
// capture and then the timer frequency in Q8 divided by that average, one
// quotient bit per clock. An empty query skips the divider. One item is in
// flight at a time; the result register lets the next input transfer be taken
// while a result still waits. The timer frequency register is written with
// cfg_we and resets to 1 MHz.
module hall_speed_direction_tracker
  import hsdt_pkg::*;
#(
  parameter int SUM_BITS   = 40,
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [FREQ_BITS-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  cmd_t  cmd;
  stat_t st;

  hsdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  hsdt_dp #(
    .SUM_BITS   (SUM_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
